>>> sv/saa_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and helpers for the skyline atlas allocator.
// No dependencies; every other file in sv/ uses this package.
package saa_pkg;

    // Atlas geometry
    localparam int MAX_BLOCK_SIZE = 128;
    localparam int MAX_BLOCKS     = 16;

    localparam int COL_W     = (MAX_BLOCK_SIZE > 1) ? $clog2(MAX_BLOCK_SIZE) : 1;
    localparam int BLK_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int ADDR_W    = BLK_W + COL_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int SKY_W     = $clog2(MAX_BLOCK_SIZE + 1);
    // Padded request size: 8-bit size plus twice a 4-bit padding
    localparam int FULL_W    = 9;
    localparam int EXT_W     = ((SKY_W > FULL_W) ? SKY_W : FULL_W) + 1;

    // Register file
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [7:0] BLOCK_SIZE_RESET = 8'd128;
    localparam logic [3:0] PADDING_RESET    = 4'd0;

    typedef enum logic [0:0] {
        REG_BLOCK_SIZE = 1'b0,
        REG_PADDING    = 1'b1
    } reg_idx_t;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [7:0] block_size;
        logic [3:0] padding;
    } cfg_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] rect_width;
        logic [7:0] rect_height;
    } req_t;

    typedef struct packed {
        logic       fail;
        logic [3:0] block_index;
        logic [6:0] x_offset;
        logic [6:0] y_offset;
    } res_t;

    // Single-port skyline memory request
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [SKY_W-1:0]  wdata;
    } ram_req_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } scan_stat_t;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_DECIDE,
        ST_RAISE,
        ST_RESULT
    } scan_state_t;

    // Block number folded into the 4-bit result field
    function automatic logic [3:0] blk_field(input logic [BLK_W-1:0] b);
        logic [BLK_W+3:0] t;
        t = {4'b0000, b};
        return t[3:0];
    endfunction

    // Offset plus padding, folded into the 7-bit result field
    function automatic logic [6:0] off_field(input logic [EXT_W-1:0] a,
                                             input logic [3:0] p);
        logic [EXT_W-1:0] s;
        s = a + EXT_W'(p);
        return s[6:0];
    endfunction

endpackage

>>> sv/skyline_atlas_allocator.sv
`timescale 1ns / 1ps
// Skyline atlas allocator top level: stream ports, output register,
// configuration registers, allocation sequencer and skyline memory.
// Depends on saa_pkg, saa_cfg_regs, saa_scan and saa_sky_ram.
//
//  Port group   Dir   Moves
//  s_t*         in    request word: tuser = cmd, tdata = width, height
//  m_t*         out   result word: tuser = fail, tdata = block, x, y
//  p*           both  register writes and reads, block_size and padding
//
// Steps: an empty or oversized request goes from accept straight to result; a
// clear first zeroes every memory entry. An allocation reads, per block scanned,
// at most (bs - pw + 1) * pw columns, as a window stops once its tallest column
// reaches the best so far, then writes pw columns to place. After reset the same
// zeroing sweep runs with s_tready low. A result waits in the sequencer only
// while the output register is full and stalled.
module skyline_atlas_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,  // [7:0] rect_width, [15:8] rect_height
    input  logic                           s_tuser,  // [0] cmd
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,  // [3:0] block_index, [10:4] x_offset,
                                                     // [17:11] y_offset, rest zero
    output logic                           m_tuser,  // [0] fail
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [saa_pkg::APB_AW-1:0]     paddr,
    input  logic [saa_pkg::APB_DW-1:0]     pwdata,
    output logic [saa_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    saa_pkg::cfg_t                cfg;
    saa_pkg::req_t                req;
    saa_pkg::res_t                res;
    saa_pkg::scan_stat_t          stat;
    saa_pkg::ram_req_t            ram_req;
    logic [saa_pkg::SKY_W-1:0]    ram_rdata;

    logic                         in_accept;
    logic                         res_load;
    logic                         out_valid_reg;
    saa_pkg::res_t                out_reg;
    logic                         pend_reg;

    saa_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Unpack the request word
    assign req.cmd         = saa_pkg::cmd_t'(s_tuser);
    assign req.rect_width  = s_tdata[7:0];
    assign req.rect_height = s_tdata[15:8];

    assign s_tready  = stat.idle;
    assign in_accept = s_tvalid && s_tready;
    assign res_load  = stat.res_valid && (!out_valid_reg || m_tready);

    saa_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (in_accept),
        .req       (req),
        .stat      (stat),
        .res       (res),
        .res_ready (res_load),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    saa_sky_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // Output register: load a new word or drop the one taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_accept)
            begin
                pend_reg <= 1'b1;
            end
            else if (res_load)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.fail;
    assign m_tdata  = {6'd0, out_reg.y_offset, out_reg.x_offset, out_reg.block_index};

`ifndef SYNTHESIS
    // A result only answers a request that is still outstanding
    a_res_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> pend_reg)
        else $error("result produced with no request outstanding");

    // No new request while the previous one is unanswered
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> !pend_reg)
        else $error("request accepted while another is outstanding");

    // A failed placement carries zero block and offsets
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 24'd0))
        else $error("failed result with nonzero payload");

    // The sequencer keeps its result until the output register takes it
    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.res_valid && !res_load) |=> stat.res_valid)
        else $error("result dropped before it was taken");
`endif

endmodule

>>> sv/saa_sky_ram.sv
`timescale 1ns / 1ps
// Skyline height memory: one port, synchronous write, registered read.
// Depends on saa_pkg for its sizes.
module saa_sky_ram (
    input  logic                                  clk,
    input  saa_pkg::ram_req_t                     req,
    output logic [saa_pkg::SKY_W-1:0]             rdata
);

    logic [saa_pkg::SKY_W-1:0] mem [saa_pkg::RAM_DEPTH];
    logic [saa_pkg::SKY_W-1:0] rdata_reg;

    // Write on request, read every cycle
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/saa_cfg_regs.sv
`timescale 1ns / 1ps
// APB-style configuration registers: block size and padding.
// Depends on saa_pkg for the register map and the cfg_t bundle.
module saa_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [saa_pkg::APB_AW-1:0]    paddr,
    input  logic [saa_pkg::APB_DW-1:0]    pwdata,
    output logic [saa_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output saa_pkg::cfg_t                 cfg
);

    logic [7:0] block_size_reg;
    logic [3:0] padding_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Capture register writes; word index is paddr[2]
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= saa_pkg::BLOCK_SIZE_RESET;
            padding_reg    <= saa_pkg::PADDING_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == saa_pkg::REG_PADDING)
            begin
                padding_reg <= pwdata[3:0];
            end
            else
            begin
                block_size_reg <= pwdata[7:0];
            end
        end
    end

    // Read back the selected register
    always_comb
    begin
        if (paddr[2] == saa_pkg::REG_PADDING)
        begin
            prdata = {28'd0, padding_reg};
        end
        else
        begin
            prdata = {24'd0, block_size_reg};
        end
    end

    assign cfg.block_size = block_size_reg;
    assign cfg.padding    = padding_reg;

endmodule

>>> sv/saa_scan.sv
`timescale 1ns / 1ps
// Allocation sequencer: scans skyline columns out of the memory, picks the
// lowest window, raises it, and sweeps the memory on reset and clear.
// Depends on saa_pkg; drives the port of saa_sky_ram.
module saa_scan (
    input  logic                              clk,
    input  logic                              rst_n,
    input  saa_pkg::cfg_t                     cfg,
    input  logic                              req_valid,
    input  saa_pkg::req_t                     req,
    output saa_pkg::scan_stat_t               stat,
    output saa_pkg::res_t                     res,
    input  logic                              res_ready,
    output saa_pkg::ram_req_t                 ram_req,
    input  logic [saa_pkg::SKY_W-1:0]         ram_rdata
);

    localparam int CW = saa_pkg::COL_W;
    localparam int BW = saa_pkg::BLK_W;
    localparam int SW = saa_pkg::SKY_W;
    localparam int EW = saa_pkg::EXT_W;
    localparam int AW = saa_pkg::ADDR_W;

    saa_pkg::scan_state_t state_reg, state_next;

    logic [AW-1:0] wipe_reg, wipe_next;
    logic          clr_res_reg, clr_res_next;
    logic [BW-1:0] blk_reg, blk_next;
    logic [CW-1:0] x_reg, x_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] bx_reg, bx_next;
    logic [CW-1:0] xlast_reg, xlast_next;
    logic [SW-1:0] top_reg, top_next;
    logic [SW-1:0] best_reg, best_next;
    logic          best_vld_reg, best_vld_next;
    logic [SW-1:0] pw_reg, pw_next;
    logic [SW-1:0] ph_reg, ph_next;
    logic [SW-1:0] bs_reg, bs_next;
    logic [3:0]    pad_reg, pad_next;
    saa_pkg::res_t res_reg, res_next;

    // Request sizing
    logic [EW-1:0] pad2_ext;
    logic [EW-1:0] pw_full;
    logic [EW-1:0] ph_full;
    logic [EW-1:0] bs_cfg;
    logic [EW-1:0] bs_eff;
    logic [EW-1:0] xlast_full;

    // Scan datapath
    logic [SW-1:0] top_new;
    logic [SW-1:0] pw_m1;
    logic          abort;
    logic          last_k;
    logic [EW-1:0] fit_sum;
    logic [SW-1:0] raise_val;

    assign pad2_ext   = EW'({cfg.padding, 1'b0});
    assign pw_full    = EW'(req.rect_width) + pad2_ext;
    assign ph_full    = EW'(req.rect_height) + pad2_ext;
    assign bs_cfg     = EW'(cfg.block_size);
    assign xlast_full = bs_eff - pw_full;

    // Clamp block size to the supported range
    always_comb
    begin
        if (bs_cfg == '0)
        begin
            bs_eff = EW'(1);
        end
        else if (bs_cfg > EW'(saa_pkg::MAX_BLOCK_SIZE))
        begin
            bs_eff = EW'(saa_pkg::MAX_BLOCK_SIZE);
        end
        else
        begin
            bs_eff = bs_cfg;
        end
    end

    assign top_new   = ((k_reg == '0) || (ram_rdata > top_reg)) ? ram_rdata : top_reg;
    assign pw_m1     = pw_reg - SW'(1);
    assign last_k    = (k_reg == pw_m1[CW-1:0]);
    assign abort     = best_vld_reg && (top_new >= best_reg);
    assign fit_sum   = EW'(best_reg) + EW'(ph_reg);
    assign raise_val = best_reg + ph_reg;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= saa_pkg::ST_WIPE;
            wipe_reg    <= '0;
            clr_res_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wipe_reg    <= wipe_next;
            clr_res_reg <= clr_res_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        blk_reg      <= blk_next;
        x_reg        <= x_next;
        k_reg        <= k_next;
        bx_reg       <= bx_next;
        xlast_reg    <= xlast_next;
        top_reg      <= top_next;
        best_reg     <= best_next;
        best_vld_reg <= best_vld_next;
        pw_reg       <= pw_next;
        ph_reg       <= ph_next;
        bs_reg       <= bs_next;
        pad_reg      <= pad_next;
        res_reg      <= res_next;
    end

    // Next state, memory port and datapath updates
    always_comb
    begin
        state_next    = state_reg;
        wipe_next     = wipe_reg;
        clr_res_next  = clr_res_reg;
        blk_next      = blk_reg;
        x_next        = x_reg;
        k_next        = k_reg;
        bx_next       = bx_reg;
        xlast_next    = xlast_reg;
        top_next      = top_reg;
        best_next     = best_reg;
        best_vld_next = best_vld_reg;
        pw_next       = pw_reg;
        ph_next       = ph_reg;
        bs_next       = bs_reg;
        pad_next      = pad_reg;
        res_next      = res_reg;
        ram_req.we    = 1'b0;
        ram_req.addr  = {blk_reg, x_reg + k_reg};
        ram_req.wdata = '0;

        case (state_reg)
            // Zero one entry per cycle
            saa_pkg::ST_WIPE:
            begin
                ram_req.we    = 1'b1;
                ram_req.addr  = wipe_reg;
                ram_req.wdata = '0;
                wipe_next     = wipe_reg + AW'(1);
                if (wipe_reg == '1)
                begin
                    res_next     = '0;
                    clr_res_next = 1'b0;
                    state_next   = clr_res_reg ? saa_pkg::ST_RESULT : saa_pkg::ST_IDLE;
                end
            end

            // Take a request and sort out the trivial outcomes
            saa_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    pad_next   = cfg.padding;
                    pw_next    = pw_full[SW-1:0];
                    ph_next    = ph_full[SW-1:0];
                    bs_next    = bs_eff[SW-1:0];
                    xlast_next = xlast_full[CW-1:0];
                    blk_next   = '0;
                    res_next   = '0;
                    if (req.cmd == saa_pkg::CMD_CLEAR)
                    begin
                        wipe_next    = '0;
                        clr_res_next = 1'b1;
                        state_next   = saa_pkg::ST_WIPE;
                    end
                    else if ((pw_full == '0) || (ph_full == '0))
                    begin
                        state_next = saa_pkg::ST_RESULT;
                    end
                    else if ((pw_full > bs_eff) || (ph_full > bs_eff))
                    begin
                        res_next.fail = 1'b1;
                        state_next    = saa_pkg::ST_RESULT;
                    end
                    else
                    begin
                        state_next = saa_pkg::ST_START;
                    end
                end
            end

            // Issue the read of column 0 of the current block
            saa_pkg::ST_START:
            begin
                ram_req.addr  = {blk_reg, {CW{1'b0}}};
                x_next        = '0;
                k_next        = '0;
                best_vld_next = 1'b0;
                state_next    = saa_pkg::ST_SCAN;
            end

            // One column per cycle; drop a window once it cannot win
            saa_pkg::ST_SCAN:
            begin
                top_next = top_new;
                if (abort || last_k)
                begin
                    if (!abort)
                    begin
                        best_next     = top_new;
                        best_vld_next = 1'b1;
                        bx_next       = x_reg;
                    end
                    k_next = '0;
                    if (x_reg == xlast_reg)
                    begin
                        state_next = saa_pkg::ST_DECIDE;
                    end
                    else
                    begin
                        x_next = x_reg + CW'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + CW'(1);
                end
                ram_req.addr = {blk_reg, x_next + k_next};
            end

            // Place here, try the next block, or give up
            saa_pkg::ST_DECIDE:
            begin
                k_next = '0;
                if (best_vld_reg && (fit_sum <= EW'(bs_reg)))
                begin
                    state_next = saa_pkg::ST_RAISE;
                end
                else if (blk_reg == BW'(saa_pkg::MAX_BLOCKS - 1))
                begin
                    res_next      = '0;
                    res_next.fail = 1'b1;
                    state_next    = saa_pkg::ST_RESULT;
                end
                else
                begin
                    blk_next   = blk_reg + BW'(1);
                    state_next = saa_pkg::ST_START;
                end
            end

            // Write the new height under the span
            saa_pkg::ST_RAISE:
            begin
                ram_req.we    = 1'b1;
                ram_req.addr  = {blk_reg, bx_reg + k_reg};
                ram_req.wdata = raise_val;
                k_next        = k_reg + CW'(1);
                if (last_k)
                begin
                    res_next.fail        = 1'b0;
                    res_next.block_index = saa_pkg::blk_field(blk_reg);
                    res_next.x_offset    = saa_pkg::off_field(EW'(bx_reg), pad_reg);
                    res_next.y_offset    = saa_pkg::off_field(EW'(best_reg), pad_reg);
                    state_next           = saa_pkg::ST_RESULT;
                end
            end

            // Hold the result until the output register takes it
            saa_pkg::ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = saa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = saa_pkg::ST_IDLE;
            end
        endcase
    end

    assign stat.idle      = (state_reg == saa_pkg::ST_IDLE);
    assign stat.res_valid = (state_reg == saa_pkg::ST_RESULT);
    assign res            = res_reg;

endmodule

>>> tb/sv/saa_alloc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the skyline atlas allocator: follows register writes, predicts
// each result word from its request word and compares it with the output stream.
// Depends on saa_pkg.
module saa_alloc_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [7:0] rect_width, [15:8] rect_height
    input  logic                          s_tuser,   // [0] cmd
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [23:0]                   m_tdata,   // [3:0] block_index, [10:4] x_offset,
                                                     // [17:11] y_offset
    input  logic                          m_tuser,   // [0] fail
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [saa_pkg::APB_AW-1:0]    paddr,
    input  logic [saa_pkg::APB_DW-1:0]    pwdata,
    input  logic                          pready,
    output int                            mismatches,
    output int                            pending
);

    // Shadow copy of the registers and of every column height
    logic [7:0]    size_reg;
    logic [3:0]    pad_reg;
    int            col_height [saa_pkg::MAX_BLOCKS][saa_pkg::MAX_BLOCK_SIZE];

    saa_pkg::res_t placements [$];
    saa_pkg::res_t want_res;
    int            fails_seen = 0;

    // Find the lowest span in the first block that has room and raise it
    function automatic saa_pkg::res_t place_rect(input logic [7:0] w, input logic [7:0] h);
        int            bs;
        int            pw;
        int            ph;
        int            best;
        int            bx;
        int            top;
        saa_pkg::res_t r;
        r  = '0;
        bs = (size_reg == 8'd0) ? 1 :
             ((int'(size_reg) > saa_pkg::MAX_BLOCK_SIZE) ? saa_pkg::MAX_BLOCK_SIZE
                                                         : int'(size_reg));
        pw = int'(w) + 2 * int'(pad_reg);
        ph = int'(h) + 2 * int'(pad_reg);
        if (pw == 0 || ph == 0)
            return r;
        if (pw > bs || ph > bs)
        begin
            r.fail = 1'b1;
            return r;
        end
        for (int b = 0; b < saa_pkg::MAX_BLOCKS; b++)
        begin
            best = 32'h7fff_ffff;
            bx   = 0;
            for (int x = 0; x + pw <= bs; x++)
            begin
                top = 0;
                for (int k = 0; k < pw; k++)
                begin
                    if (col_height[b][x + k] > top)
                        top = col_height[b][x + k];
                end
                if (top < best)
                begin
                    best = top;
                    bx   = x;
                end
            end
            if (best + ph <= bs)
            begin
                for (int k = 0; k < pw; k++)
                    col_height[b][bx + k] = best + ph;
                r.block_index = 4'(b);
                r.x_offset    = 7'(bx + int'(pad_reg));
                r.y_offset    = 7'(best + int'(pad_reg));
                return r;
            end
        end
        r.fail = 1'b1;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails_seen++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg = saa_pkg::BLOCK_SIZE_RESET;
            pad_reg  = saa_pkg::PADDING_RESET;
            foreach (col_height[b, c])
                col_height[b][c] = 0;
            placements.delete();
            pending    <= 0;
            mismatches <= fails_seen;
        end
        else
        begin
            // Track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (saa_pkg::reg_idx_t'(paddr[2]))
                    saa_pkg::REG_BLOCK_SIZE: size_reg = pwdata[7:0];
                    saa_pkg::REG_PADDING:    pad_reg  = pwdata[3:0];
                    default:                 ;
                endcase
            end

            // Predict the result of each accepted request word
            if (s_tvalid && s_tready)
            begin
                if (saa_pkg::cmd_t'(s_tuser) == saa_pkg::CMD_CLEAR)
                begin
                    foreach (col_height[b, c])
                        col_height[b][c] = 0;
                    placements.insert(placements.size(), '0);
                end
                else
                    placements.insert(placements.size(),
                                      place_rect(s_tdata[7:0], s_tdata[15:8]));
            end

            // Compare each result word with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (placements.size() == 0)
                begin
                    $display("%0t ns: result word with nothing expected, expected none, %s",
                             $time, "actual:");
                    $display("    fail %0d block %0d x %0d y %0d",
                             m_tuser, m_tdata[3:0], m_tdata[10:4], m_tdata[17:11]);
                    fails_seen++;
                end
                else
                begin
                    want_res = placements.pop_front();
                    check_field("fail", int'(want_res.fail), int'(m_tuser));
                    check_field("block_index", int'(want_res.block_index),
                                int'(m_tdata[3:0]));
                    check_field("x_offset", int'(want_res.x_offset), int'(m_tdata[10:4]));
                    check_field("y_offset", int'(want_res.y_offset), int'(m_tdata[17:11]));
                end
            end

            pending    <= placements.size();
            mismatches <= fails_seen;
        end
    end

endmodule

>>> tb/sv/tb_skyline_atlas_allocator.sv
`timescale 1ns / 1ps
// Top of the skyline atlas allocator testbench: clock, reset, request and
// register stimulus, output stalls, watchdog and verdict.
// Depends on saa_pkg, skyline_atlas_allocator and saa_alloc_checker.
module tb_skyline_atlas_allocator;

    localparam int QUIET_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PAW           = saa_pkg::APB_AW;
    localparam int PDW           = saa_pkg::APB_DW;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_MOSTLY,
        RX_CHOKE
    } rx_mode_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata  = '0;
    logic              s_tuser  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [23:0]       m_tdata;
    logic              m_tuser;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [PAW-1:0]    paddr    = '0;
    logic [PDW-1:0]    pwdata   = '0;
    logic [PDW-1:0]    prdata;
    logic              pready;

    int       mismatches;
    int       pending;
    int       quiet_cycles = 0;
    int       burst_left   = 0;
    int       cur_bs       = 128;
    int       cur_pad      = 0;
    rx_mode_t rx_mode      = RX_OPEN;
    int       rx_run       = 0;

    always #1 clk = ~clk;

    skyline_atlas_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    saa_alloc_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Stall the result stream in stretches of different density
    always @(posedge clk)
    begin
        if (rx_run == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_run  <= $urandom_range(4, 40);
        end
        else
            rx_run <= rx_run - 1;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            default:   m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Give up when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("skyline_atlas_allocator regression: fail");
            $finish;
        end
    end

    // Send one request word, opening a new burst after a random gap
    task automatic push_word(input saa_pkg::cmd_t cmd, input int w, input int h);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {h[7:0], w[7:0]};
        do @(posedge clk); while (!s_tready);
        burst_left--;
    endtask

    // Hold off until every result word has come back
    task automatic drain();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input saa_pkg::reg_idx_t idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PAW'({idx, 2'b00});
        pwdata  <= PDW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (idx == saa_pkg::REG_BLOCK_SIZE)
            cur_bs = value & 255;
        else
            cur_pad = value & 15;
    endtask

    task automatic set_config(input int bs, input int pad);
        drain();
        write_reg(saa_pkg::REG_BLOCK_SIZE, bs);
        write_reg(saa_pkg::REG_PADDING, pad);
    endtask

    // Mostly rectangles that fit the current block, some noise and clears
    task automatic random_words(input int n);
        int lim;
        int w;
        int h;
        int pick;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            lim  = ((cur_bs == 0) ? 1 :
                    ((cur_bs > saa_pkg::MAX_BLOCK_SIZE) ? saa_pkg::MAX_BLOCK_SIZE : cur_bs))
                   - 2 * cur_pad;
            if (pick < 3)
                push_word(saa_pkg::CMD_CLEAR, $urandom_range(0, 128), $urandom_range(0, 128));
            else if (pick < 10 || lim < 0)
                push_word(saa_pkg::CMD_ALLOC, $urandom_range(0, 128), $urandom_range(0, 128));
            else
            begin
                w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lim)
                                                : $urandom_range(0, (lim + 3) / 4);
                h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lim)
                                                : $urandom_range(0, (lim + 3) / 4);
                push_word(saa_pkg::CMD_ALLOC, w, h);
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: empty rectangles, a full block, spill into the next block
        push_word(saa_pkg::CMD_ALLOC, 0, 7);
        push_word(saa_pkg::CMD_ALLOC, 128, 128);
        push_word(saa_pkg::CMD_ALLOC, 1, 1);
        push_word(saa_pkg::CMD_ALLOC, 127, 1);
        push_word(saa_pkg::CMD_ALLOC, 128, 0);

        // Widest padding: exact fit, oversized, padding-only rectangle
        set_config(128, 15);
        push_word(saa_pkg::CMD_ALLOC, 98, 98);
        push_word(saa_pkg::CMD_ALLOC, 99, 1);
        push_word(saa_pkg::CMD_ALLOC, 0, 0);

        // One-texel blocks: fill every block, then one more finds no room
        set_config(1, 0);
        push_word(saa_pkg::CMD_CLEAR, 0, 0);
        repeat (17) push_word(saa_pkg::CMD_ALLOC, 1, 1);

        // Random phases; sizes change without clearing the skylines in between
        set_config(16, 0);
        random_words(200);
        set_config(32, 1);
        random_words(150);
        set_config(8, 0);
        random_words(140);
        set_config(1, 0);
        random_words(30);
        set_config(0, 0);
        random_words(20);
        set_config(64, 3);
        random_words(100);
        set_config(255, 15);
        random_words(25);
        set_config(128, 0);
        random_words(30);
        set_config(12, 2);
        random_words(150);
        set_config(24, 0);
        random_words(130);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("skyline_atlas_allocator regression: pass");
        else
            $display("skyline_atlas_allocator regression: fail");
        $finish;
    end

endmodule
